### hw/rtl/abtt_pkg.sv
// Shared types and constants for the active button timeout table.
`default_nettype none

package abtt_pkg;

    // Table depth default and timeout register reset value
    localparam int unsigned ENTRIES_DEF   = 5;
    localparam logic [7:0]  TIMEOUT_RESET = 8'd60;

    // Field widths
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned MS_W    = 8;
    localparam int unsigned ADDR_W  = 8;
    localparam int unsigned BTN_W   = 8;
    localparam int unsigned IDX_W   = 4;

    // Configuration register indexes
    localparam logic REG_TIMEOUT = 1'b0;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PRESS   = 2'd0,
        CMD_SCAN    = 2'd1,
        CMD_TAKE    = 2'd2,
        CMD_REFRESH = 2'd3
    } cmd_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // capture input transfer, set walk index
        logic step;        // advance walk index
        logic stamp;       // restamp current entry if occupied
        logic insert;      // write new entry into recorded empty slot
        logic clear;       // mark current entry empty
        logic note_empty;  // remember first empty entry seen
        logic post;        // load result register
        logic ok;          // ok bit of result
        logic idx_cur;     // result index from walk index, else start index
        logic ev_cur;      // event fields from current entry, else zero
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        cmd_t cmd;
        logic addr_zero;
        logic start_oor;
        logic last;
        logic hit;
    } ctl_stat_t;

endpackage

`default_nettype wire

### hw/rtl/active_button_timeout_table.sv
// Sequence: a command is accepted in idle, then the datapath walks the table one entry per
// cycle; take and address zero press post without a walk, and a press with no match ends with an insert step.
// Commands are handled one at a time; the result post waits while the output register is full.
// A finished result waits in the output register while the next command is taken.
// Reset (asynchronous, active low) empties every entry, sets timeout_ms to 60 and
// drops any pending result.
`default_nettype none

module active_button_timeout_table
    import abtt_pkg::*;
#(
    parameter int unsigned ENTRIES = ENTRIES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [31:0] s_tdata,  // cmd[1:0], now_ms[9:2], addr[17:10],
                                       // button_number[25:18], start_index[29:26]
    // Result stream
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [23:0] m_tdata,  // ok[0], index[4:1], event_addr[12:5],
                                       // event_button[20:13]
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    logic [MS_W-1:0]   timeout_ms_reg;
    logic              cfg_wr;
    ctl_cmd_t          ctl;
    ctl_stat_t         stat;
    logic              res_ok;
    logic [IDX_W-1:0]  res_index;
    logic [ADDR_W-1:0] res_addr;
    logic [BTN_W-1:0]  res_button;

    // Register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TIMEOUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ms_reg <= TIMEOUT_RESET;
        end
        else if (cfg_wr)
        begin
            timeout_ms_reg <= pwdata[MS_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_TIMEOUT) ? {24'd0, timeout_ms_reg} : 32'd0;

    abtt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    abtt_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .stat             (stat),
        .timeout_ms       (timeout_ms_reg),
        .in_cmd           (cmd_t'(s_tdata[1:0])),
        .in_now_ms        (s_tdata[9:2]),
        .in_addr          (s_tdata[17:10]),
        .in_button_number (s_tdata[25:18]),
        .in_start_index   (s_tdata[29:26]),
        .ok               (res_ok),
        .index            (res_index),
        .event_addr       (res_addr),
        .event_button     (res_button)
    );

    // Result packing
    assign m_tdata = {3'd0, res_button, res_addr, res_index, res_ok};

endmodule

`default_nettype wire

### hw/rtl/abtt_datapath.sv
// Datapath: item registers, entry table, walk index and result register.
`default_nettype none

module abtt_datapath
    import abtt_pkg::*;
#(
    parameter int unsigned ENTRIES = ENTRIES_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctl_cmd_t          ctl,
    output      ctl_stat_t         stat,
    input  wire logic [MS_W-1:0]   timeout_ms,
    input  wire cmd_t              in_cmd,
    input  wire logic [MS_W-1:0]   in_now_ms,
    input  wire logic [ADDR_W-1:0] in_addr,
    input  wire logic [BTN_W-1:0]  in_button_number,
    input  wire logic [IDX_W-1:0]  in_start_index,
    output      logic              ok,
    output      logic [IDX_W-1:0]  index,
    output      logic [ADDR_W-1:0] event_addr,
    output      logic [BTN_W-1:0]  event_button
);

    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [IDX_W-1:0] NUM_IDX  = IDX_W'(ENTRIES);

    // Item registers
    cmd_t              cmd_reg;
    logic [MS_W-1:0]   now_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [BTN_W-1:0]  btn_reg;
    logic [IDX_W-1:0]  start_reg;

    // Walk state
    logic [IDX_W-1:0]  cur_reg;
    logic [IW-1:0]     empty_slot_reg;
    logic              have_empty_reg;

    // Entry table
    logic [ADDR_W-1:0] tab_addr_reg  [ENTRIES];
    logic [BTN_W-1:0]  tab_btn_reg   [ENTRIES];
    logic [MS_W-1:0]   tab_stamp_reg [ENTRIES];

    // Result register
    logic              ok_reg;
    logic [IDX_W-1:0]  index_reg;
    logic [ADDR_W-1:0] ev_addr_reg;
    logic [BTN_W-1:0]  ev_btn_reg;

    logic [IW-1:0]     ci;
    logic [ADDR_W-1:0] cur_addr;
    logic [BTN_W-1:0]  cur_btn;
    logic [MS_W-1:0]   cur_age;
    logic              cur_occ;
    logic              cur_match;
    logic              cur_released;

    // Current entry read and compares
    assign ci           = cur_reg[IW-1:0];
    assign cur_addr     = tab_addr_reg[ci];
    assign cur_btn      = tab_btn_reg[ci];
    assign cur_age      = now_reg - tab_stamp_reg[ci];
    assign cur_occ      = (cur_addr != '0);
    assign cur_match    = (cur_addr == addr_reg) && (cur_btn == btn_reg);
    assign cur_released = (cur_age > timeout_ms);

    always_comb
    begin
        stat.cmd       = cmd_reg;
        stat.addr_zero = (addr_reg == '0);
        stat.start_oor = (start_reg >= NUM_IDX);
        stat.last      = (cur_reg == LAST_IDX);
        stat.hit       = cur_occ && ((cmd_reg == CMD_PRESS) ? cur_match : cur_released);
    end

    // Walk index and empty slot tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg        <= '0;
            have_empty_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            cur_reg        <= (in_cmd == CMD_SCAN || in_cmd == CMD_TAKE) ? in_start_index : '0;
            have_empty_reg <= 1'b0;
        end
        else
        begin
            if (ctl.note_empty && !have_empty_reg && !cur_occ)
            begin
                have_empty_reg <= 1'b1;
            end
            if (ctl.step)
            begin
                cur_reg <= cur_reg + 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg   <= in_cmd;
            now_reg   <= in_now_ms;
            addr_reg  <= in_addr;
            btn_reg   <= in_button_number;
            start_reg <= in_start_index;
        end
        if (ctl.note_empty && !have_empty_reg && !cur_occ)
        begin
            empty_slot_reg <= ci;
        end
        if (ctl.post)
        begin
            ok_reg      <= ctl.ok;
            index_reg   <= ctl.idx_cur ? cur_reg : start_reg;
            ev_addr_reg <= ctl.ev_cur ? cur_addr : '0;
            ev_btn_reg  <= ctl.ev_cur ? cur_btn : '0;
        end
    end

    // Entry addresses: reset to empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                tab_addr_reg[i] <= '0;
            end
        end
        else if (ctl.insert && have_empty_reg)
        begin
            tab_addr_reg[empty_slot_reg] <= addr_reg;
        end
        else if (ctl.clear)
        begin
            tab_addr_reg[ci] <= '0;
        end
    end

    // Entry button numbers and stamps
    always_ff @(posedge clk)
    begin
        if (ctl.insert && have_empty_reg)
        begin
            tab_btn_reg[empty_slot_reg]   <= btn_reg;
            tab_stamp_reg[empty_slot_reg] <= now_reg;
        end
        else if (ctl.stamp && cur_occ)
        begin
            tab_stamp_reg[ci] <= now_reg;
        end
    end

    assign ok           = ok_reg;
    assign index        = index_reg;
    assign event_addr   = ev_addr_reg;
    assign event_button = ev_btn_reg;

endmodule

`default_nettype wire

### hw/rtl/abtt_ctrl.sv
// Controller: sequences one command over the entry table and the output handshake.
`default_nettype none

module abtt_ctrl
    import abtt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    output      logic      s_tready,
    output      logic      m_tvalid,
    input  wire logic      m_tready,
    input  wire ctl_stat_t stat,
    output      ctl_cmd_t  ctl
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_INSERT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   can_post;

    assign can_post = !out_valid_reg || m_tready;

    // Command decode per state
    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                unique case (stat.cmd)
                    CMD_PRESS:
                    begin
                        if (stat.addr_zero || stat.hit)
                        begin
                            if (can_post)
                            begin
                                ctl.stamp  = stat.hit;
                                ctl.post   = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        else
                        begin
                            ctl.note_empty = 1'b1;
                            if (stat.last)
                            begin
                                state_next = ST_INSERT;
                            end
                            else
                            begin
                                ctl.step = 1'b1;
                            end
                        end
                    end
                    CMD_SCAN:
                    begin
                        if (stat.start_oor || stat.hit || stat.last)
                        begin
                            if (can_post)
                            begin
                                ctl.post    = 1'b1;
                                ctl.ok      = !stat.start_oor && stat.hit;
                                ctl.idx_cur = !stat.start_oor && stat.hit;
                                state_next  = ST_IDLE;
                            end
                        end
                        else
                        begin
                            ctl.step = 1'b1;
                        end
                    end
                    CMD_TAKE:
                    begin
                        if (can_post)
                        begin
                            ctl.post   = 1'b1;
                            ctl.ok     = !stat.start_oor;
                            ctl.ev_cur = !stat.start_oor;
                            ctl.clear  = !stat.start_oor;
                            state_next = ST_IDLE;
                        end
                    end
                    CMD_REFRESH:
                    begin
                        ctl.stamp = 1'b1;
                        if (stat.last)
                        begin
                            if (can_post)
                            begin
                                ctl.post   = 1'b1;
                                ctl.ok     = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        else
                        begin
                            ctl.step = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_INSERT:
            begin
                if (can_post)
                begin
                    ctl.insert = 1'b1;
                    ctl.post   = 1'b1;
                    ctl.ok     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output slot: filled on post, emptied on transfer
    assign out_valid_next = ctl.post | (out_valid_reg & !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire
